// File: hw/rtl/dssd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dssd_pkg
// shared types, chip sequence tables and register codes for the despreader
// ----------------------------------------------------------------------------
package dssd_pkg;

  localparam int CHIP_W   = 32;
  localparam int SYM_W    = 8;
  localparam int THR_W    = 6;
  localparam int ERR_W    = 6;
  localparam int IDX_W    = 4;
  localparam int NUM_LANE = 16;
  localparam int NUM_DBPSK = 2;
  localparam int NUM_BYTE = CHIP_W / 8;
  localparam int BCNT_W   = 4;

  localparam int PADDR_W  = 3;
  localparam int REG_IDX_W = 1;
  localparam int PDATA_W  = 32;

  localparam logic [REG_IDX_W-1:0] REG_MODE_SELECT    = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_ERROR_THRESHOLD = 1'b1;

  localparam logic MODE_DBPSK = 1'b0;
  localparam logic MODE_OQPSK = 1'b1;

  localparam logic [CHIP_W-1:0] MASK_DBPSK = 32'h0000_7fff;
  localparam logic [CHIP_W-1:0] MASK_OQPSK = 32'hffff_ffff;
  localparam logic [SYM_W-1:0]  NO_MATCH_SYMBOL = 8'hff;

  localparam logic [CHIP_W-1:0] SEQ_DBPSK [NUM_DBPSK] = '{
    32'h0000_09af, 32'h0000_7650
  };

  localparam logic [CHIP_W-1:0] SEQ_OQPSK [NUM_LANE] = '{
    32'h6077_ae6c, 32'h4e07_7ae6, 32'h6ce0_77ae, 32'h66ce_077a,
    32'h2e6c_e077, 32'h7ae6_ce07, 32'h77ae_6ce0, 32'h077a_e6ce,
    32'h1f88_5193, 32'h31f8_8519, 32'h131f_8851, 32'h1931_f885,
    32'h5193_1f88, 32'h0519_31f8, 32'h0851_931f, 32'h7885_1931
  };

  typedef struct packed {
    logic             ok;
    logic [ERR_W-1:0] err;
    logic [IDX_W-1:0] idx;
  } cand_t;

  function automatic logic [BCNT_W-1:0] popcount8(input logic [7:0] v);
    logic [BCNT_W-1:0] n;
    n = '0;
    for (int b = 0; b < 8; b++) begin
      n = n + BCNT_W'(v[b]);
    end
    return n;
  endfunction

  // a is the lower index, so it wins a tie
  function automatic cand_t pick(input cand_t a, input cand_t b);
    if (a.ok && (!b.ok || a.err <= b.err)) begin
      return a;
    end
    return b;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/dssd_chip_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dssd_chip_if
// valid/ready channel carrying one received chip word
// ----------------------------------------------------------------------------
interface dssd_chip_if;
  logic                        valid;
  logic                        ready;
  logic [dssd_pkg::CHIP_W-1:0] chip_word;

  modport source (output valid, output chip_word, input ready);
  modport sink (input valid, input chip_word, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/dssd_sym_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dssd_sym_if
// valid/ready channel carrying one decoded symbol and its match status
// ----------------------------------------------------------------------------
interface dssd_sym_if;
  logic                       valid;
  logic                       ready;
  logic [dssd_pkg::SYM_W-1:0] symbol;
  logic                       status;

  modport source (output valid, output symbol, output status, input ready);
  modport sink (input valid, input symbol, input status, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/dsss_chip_to_symbol_despreader.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dsss_chip_to_symbol_despreader
// nearest chip sequence search over the selected mode's table, 4 stages
// ----------------------------------------------------------------------------
// path: a chip word moves through the stage 1 to stage 4 registers to symbol valid
// throughput: one chip word per cycle; the whole pipe holds while the output
//   register is full and not taken
// reset: valid bits clear, mode_select returns to o-qpsk, threshold to 0
// stages: byte popcounts, lane error sums and threshold check, 16-to-4 pick,
//   4-to-1 pick into the output register
module dsss_chip_to_symbol_despreader (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               psel,
  input  wire                               penable,
  input  wire                               pwrite,
  input  wire  [dssd_pkg::PADDR_W-1:0]      paddr,
  input  wire  [dssd_pkg::PDATA_W-1:0]      pwdata,
  output logic [dssd_pkg::PDATA_W-1:0]      prdata,
  output logic                              pready,
  dssd_chip_if.sink                         chip_in,
  dssd_sym_if.source                        sym_out
);

  localparam int NL = dssd_pkg::NUM_LANE;
  localparam int NG = NL / 4;

  logic                          mode_select;
  logic [dssd_pkg::THR_W-1:0]    error_threshold;
  logic [dssd_pkg::REG_IDX_W-1:0] reg_idx;

  logic adv;

  logic                                              v1;
  logic [NL-1:0][dssd_pkg::NUM_BYTE-1:0][dssd_pkg::BCNT_W-1:0] cnt1;
  logic [NL-1:0]                                     act1;

  logic                v2;
  dssd_pkg::cand_t     cand2 [NL];
  logic                v3;
  dssd_pkg::cand_t     cand3 [NG];
  logic                v4;
  logic [dssd_pkg::SYM_W-1:0] symbol;
  logic                status;

  // configuration port
  assign pready  = 1'b1;
  assign reg_idx = paddr[dssd_pkg::PADDR_W-1 -: dssd_pkg::REG_IDX_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_select     <= dssd_pkg::MODE_OQPSK;
      error_threshold <= '0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        dssd_pkg::REG_MODE_SELECT:     mode_select     <= pwdata[0];
        dssd_pkg::REG_ERROR_THRESHOLD: error_threshold <= pwdata[dssd_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      dssd_pkg::REG_MODE_SELECT:     prdata[0] = mode_select;
      dssd_pkg::REG_ERROR_THRESHOLD: prdata[dssd_pkg::THR_W-1:0] = error_threshold;
      default: ;
    endcase
  end

  // the whole pipe moves unless the output register holds an untaken result
  assign adv           = !v4 || sym_out.ready;
  assign chip_in.ready = adv;

  // stage 1: mask, xor against each sequence, popcount per byte
  always_ff @(posedge clk) begin
    logic [dssd_pkg::CHIP_W-1:0] word;
    logic [dssd_pkg::CHIP_W-1:0] seq;
    logic [dssd_pkg::CHIP_W-1:0] diff;
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= chip_in.valid;
    end
    if (adv) begin
      word = (mode_select == dssd_pkg::MODE_DBPSK) ?
             (chip_in.chip_word & dssd_pkg::MASK_DBPSK) :
             (chip_in.chip_word & dssd_pkg::MASK_OQPSK);
      for (int k = 0; k < NL; k++) begin
        if (mode_select == dssd_pkg::MODE_DBPSK) begin
          seq = (k < dssd_pkg::NUM_DBPSK) ?
                dssd_pkg::SEQ_DBPSK[k % dssd_pkg::NUM_DBPSK] : '0;
          act1[k] <= (k < dssd_pkg::NUM_DBPSK);
        end else begin
          seq = dssd_pkg::SEQ_OQPSK[k];
          act1[k] <= 1'b1;
        end
        diff = seq ^ word;
        for (int b = 0; b < dssd_pkg::NUM_BYTE; b++) begin
          cnt1[k][b] <= dssd_pkg::popcount8(diff[b*8 +: 8]);
        end
      end
    end
  end

  // stage 2: error count per lane and threshold check
  always_ff @(posedge clk) begin
    logic [dssd_pkg::ERR_W-1:0] err;
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
    if (adv) begin
      for (int k = 0; k < NL; k++) begin
        err = '0;
        for (int b = 0; b < dssd_pkg::NUM_BYTE; b++) begin
          err = err + dssd_pkg::ERR_W'(cnt1[k][b]);
        end
        cand2[k].err <= err;
        cand2[k].idx <= dssd_pkg::IDX_W'(k);
        cand2[k].ok  <= act1[k] && (err <= error_threshold);
      end
    end
  end

  // stage 3: best of each group of four lanes
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
    if (adv) begin
      for (int g = 0; g < NG; g++) begin
        cand3[g] <= dssd_pkg::pick(
          dssd_pkg::pick(cand2[4*g],     cand2[4*g + 1]),
          dssd_pkg::pick(cand2[4*g + 2], cand2[4*g + 3]));
      end
    end
  end

  // stage 4: overall best into the output register
  always_ff @(posedge clk) begin
    dssd_pkg::cand_t best;
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= v3;
    end
    if (adv) begin
      best = dssd_pkg::pick(dssd_pkg::pick(cand3[0], cand3[1]),
                            dssd_pkg::pick(cand3[2], cand3[3]));
      symbol <= best.ok ? dssd_pkg::SYM_W'(best.idx) : dssd_pkg::NO_MATCH_SYMBOL;
      status <= !best.ok;
    end
  end

  assign sym_out.valid  = v4;
  assign sym_out.symbol = symbol;
  assign sym_out.status = status;

  // no-match flag and reserved symbol always agree
  a_status_symbol: assert property (@(posedge clk) disable iff (rst)
    sym_out.valid |-> (sym_out.status == (sym_out.symbol == dssd_pkg::NO_MATCH_SYMBOL)))
    else $error("status and symbol disagree");

  // a matched symbol is a table index
  a_symbol_range: assert property (@(posedge clk) disable iff (rst)
    (sym_out.valid && !sym_out.status) |-> (sym_out.symbol < 8'd16))
    else $error("matched symbol out of table range");

  // a transfer in always lands in the first stage
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (chip_in.valid && chip_in.ready) |=> v1)
    else $error("accepted chip word lost at pipe entry");

endmodule
`default_nettype wire

// File: bench/dsss_chip_to_symbol_despreader_test.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dsss_chip_to_symbol_despreader_test
// Drives chip words through the despreader under both modes and a range of
// error thresholds. Each decoded symbol and match flag is checked against a
// nearest-sequence search. Idle bursts are placed on both channels, with one
// long output stall and one sender pause.
// ----------------------------------------------------------------------------
module dsss_chip_to_symbol_despreader_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 500_000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [dssd_pkg::CHIP_W-1:0] chip;
    logic [dssd_pkg::SYM_W-1:0]  symbol;
    logic                        status;
  } sym_result_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [dssd_pkg::PADDR_W-1:0] paddr;
  logic [dssd_pkg::PDATA_W-1:0] pwdata;
  logic [dssd_pkg::PDATA_W-1:0] prdata;
  logic pready;

  dssd_chip_if chip_in ();
  dssd_sym_if  sym_out ();

  dsss_chip_to_symbol_despreader dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .chip_in (chip_in),
    .sym_out (sym_out)
  );

  // local copy of the register file
  logic                       cur_mode;
  logic [dssd_pkg::THR_W-1:0] cur_thr;

  sym_result_t pending_symbols[$];
  int unsigned fail_count;
  int unsigned cycle_count;

  bit src_idle_en;
  bit sink_idle_en;
  int unsigned hold_request;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d symbols pending", $time, pending_symbols.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // nearest sequence within threshold, lowest index on a tie
  function automatic sym_result_t despread_word(input logic [dssd_pkg::CHIP_W-1:0] w,
                                                input logic mode,
                                                input logic [dssd_pkg::THR_W-1:0] thr);
    sym_result_t r;
    logic [dssd_pkg::CHIP_W-1:0] m;
    logic [dssd_pkg::CHIP_W-1:0] seq;
    int n_seq;
    int best;
    int err;
    r.chip   = w;
    r.symbol = dssd_pkg::NO_MATCH_SYMBOL;
    r.status = 1'b1;
    best     = 1000;
    if (mode == dssd_pkg::MODE_DBPSK) begin
      m     = dssd_pkg::MASK_DBPSK;
      n_seq = dssd_pkg::NUM_DBPSK;
    end else begin
      m     = dssd_pkg::MASK_OQPSK;
      n_seq = dssd_pkg::NUM_LANE;
    end
    for (int i = 0; i < n_seq; i++) begin
      if (mode == dssd_pkg::MODE_DBPSK) begin
        seq = dssd_pkg::SEQ_DBPSK[i];
      end else begin
        seq = dssd_pkg::SEQ_OQPSK[i];
      end
      err = $countones((w ^ seq) & m);
      if (err <= int'(thr) && err < best) begin
        best     = err;
        r.symbol = dssd_pkg::SYM_W'(i);
        r.status = 1'b0;
      end
    end
    return r;
  endfunction

  // a table sequence with a few chip errors, or a plain random word
  function automatic logic [dssd_pkg::CHIP_W-1:0] noisy_chip();
    logic [dssd_pkg::CHIP_W-1:0] w;
    int chips;
    int max_flips;
    chips = (cur_mode == dssd_pkg::MODE_DBPSK) ? 15 : dssd_pkg::CHIP_W;
    if ($urandom_range(0, 9) < 3) begin
      return $urandom;
    end
    if (cur_mode == dssd_pkg::MODE_DBPSK) begin
      w = dssd_pkg::SEQ_DBPSK[$urandom_range(0, dssd_pkg::NUM_DBPSK - 1)] |
          ($urandom & ~dssd_pkg::MASK_DBPSK);
    end else begin
      w = dssd_pkg::SEQ_OQPSK[$urandom_range(0, dssd_pkg::NUM_LANE - 1)];
    end
    max_flips = (int'(cur_thr) > chips / 2) ? chips / 2 + 2 : int'(cur_thr) + 2;
    repeat ($urandom_range(0, max_flips)) begin
      w[$urandom_range(0, chips - 1)] ^= 1'b1;
    end
    return w;
  endfunction

  task automatic send_chip(input logic [dssd_pkg::CHIP_W-1:0] w);
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      chip_in.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    chip_in.valid     <= 1'b1;
    chip_in.chip_word <= w;
    do @(posedge clk); while (!chip_in.ready);
    pending_symbols.push_back(despread_word(w, cur_mode, cur_thr));
  endtask

  task automatic drain_symbols();
    chip_in.valid <= 1'b0;
    while (pending_symbols.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [dssd_pkg::REG_IDX_W-1:0] idx,
                           input logic [dssd_pkg::PDATA_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == dssd_pkg::REG_MODE_SELECT) begin
      cur_mode = value[0];
    end else begin
      cur_thr = value[dssd_pkg::THR_W-1:0];
    end
  endtask

  task automatic set_config(input logic [dssd_pkg::PDATA_W-1:0] mode_val,
                            input logic [dssd_pkg::PDATA_W-1:0] thr_val);
    drain_symbols();
    write_reg(dssd_pkg::REG_MODE_SELECT, mode_val);
    write_reg(dssd_pkg::REG_ERROR_THRESHOLD, thr_val);
  endtask

  task automatic run_items(input int n);
    repeat (n) send_chip(noisy_chip());
  endtask

  // reset config is o-qpsk with zero threshold: only exact sequences match
  task automatic test_reset_defaults();
    for (int i = 0; i < dssd_pkg::NUM_LANE; i++) begin
      send_chip(dssd_pkg::SEQ_OQPSK[i]);
    end
    send_chip('0);
    send_chip('1);
  endtask

  // dbpsk ignores chips 15..31; mode value with upper bits set keeps bit 0
  task automatic test_dbpsk_upper_chips();
    set_config(32'h0000_0002, 32'h0000_0000);
    send_chip(32'hffff_89af);
    send_chip(32'habcd_7650);
    send_chip(32'h0000_8000);
  endtask

  // threshold written wide keeps its low bits; 63 accepts every word
  task automatic test_wide_threshold();
    set_config(32'hffff_ffff, 32'hffff_ffff);
    send_chip('0);
    send_chip('1);
    send_chip(32'h5555_5555);
  endtask

  task automatic test_random_phases();
    logic [dssd_pkg::PDATA_W-1:0] thr_plan [9];
    thr_plan = '{32'd0, 32'd32, 32'd2, 32'd5, 32'd7, 32'd12, 32'h0000_0041, 32'd1,
                 32'hffff_ffff};
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    for (int p = 0; p < 9; p++) begin
      set_config(dssd_pkg::PDATA_W'({$urandom, 1'b0}) |
                 dssd_pkg::PDATA_W'(p % 2 == 1 || p == 8), thr_plan[p]);
      if (p == 4) begin
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
      end else begin
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
      end
      run_items(110);
    end
  endtask

  // output held off long enough that the pipe fills and stalls the input
  task automatic test_output_stall();
    set_config(32'd1, 32'd3);
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    hold_request = 80;
    run_items(100);
  endtask

  task automatic test_sender_pause();
    set_config(32'd0, 32'd4);
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    run_items(30);
    drain_symbols();
    run_items(30);
  endtask

  // threshold above the dbpsk chip count, back to back with no gaps
  task automatic test_quiet_tail();
    set_config(32'd0, 32'd20);
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    run_items(80);
  endtask

  // result side: random stalls plus the long hold when requested
  initial begin
    int unsigned hold_left;
    int unsigned gap_left;
    hold_left = 0;
    gap_left  = 0;
    sym_out.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        sym_out.ready <= 1'b0;
      end else if (gap_left != 0) begin
        gap_left--;
        sym_out.ready <= 1'b0;
      end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
        gap_left = $urandom_range(1, 15) - 1;
        sym_out.ready <= 1'b0;
      end else begin
        sym_out.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    sym_result_t want;
    if (!rst && sym_out.valid && sym_out.ready) begin
      if (pending_symbols.size() == 0) begin
        $display("%0t: unexpected transfer: symbol %0d status %0d", $time, sym_out.symbol,
                 sym_out.status);
        fail_count++;
      end else begin
        want = pending_symbols.pop_front();
        if (sym_out.symbol !== want.symbol) begin
          $display("%0t: chip word %h: symbol expected %0d, actual %0d", $time, want.chip,
                   want.symbol, sym_out.symbol);
          fail_count++;
        end
        if (sym_out.status !== want.status) begin
          $display("%0t: chip word %h: status expected %0d, actual %0d", $time, want.chip,
                   want.status, sym_out.status);
          fail_count++;
        end
      end
    end
  end

  initial begin
    fail_count   = 0;
    cycle_count  = 0;
    hold_request = 0;
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    cur_mode     = dssd_pkg::MODE_OQPSK;
    cur_thr      = '0;
    rst               <= 1'b1;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    chip_in.valid     <= 1'b0;
    chip_in.chip_word <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_dbpsk_upper_chips();
    test_wide_threshold();
    test_random_phases();
    test_output_stall();
    test_sender_pause();
    test_quiet_tail();

    drain_symbols();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
`default_nettype wire
